// ===== rtl/cst_pkg.sv =====
// Package: shared types and constants for the colour sort tracker.
package cst_pkg;

  // Sample class codes as they appear on the result channel.
  typedef enum logic [1:0] {
    COL_NONE = 2'd0,
    COL_RED  = 2'd1,
    COL_BLUE = 2'd2
  } colour_t;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_SORT_ENABLE   = 3'd0;
  localparam logic [2:0] REG_TEAM_IS_RED   = 3'd1;
  localparam logic [2:0] REG_PROX_THRESH   = 3'd2;
  localparam logic [2:0] REG_DIST_THRESH   = 3'd3;
  localparam logic [2:0] REG_RED_HUE_LIMIT = 3'd4;
  localparam logic [2:0] REG_BLUE_HUE_LIM  = 3'd5;

  localparam int ADDR_W = 5;

  // Register reset values.
  localparam logic       RST_SORT_ENABLE = 1'b1;
  localparam logic       RST_TEAM_IS_RED = 1'b1;
  localparam logic [7:0] RST_PROX_THRESH = 8'd100;
  localparam logic [13:0] RST_DIST_THRESH = 14'd50;
  localparam logic [8:0] RST_RED_HUE     = 9'd30;
  localparam logic [8:0] RST_BLUE_HUE    = 9'd100;

  // Per-cycle control broadcast to every queue cell.
  typedef struct packed {
    logic push;       // a new colour enters at the first empty cell
    logic pop;        // front leaves, everything moves one cell down
    logic blue;       // colour bit of the pushed item (1 blue, 0 red)
  } cell_ctrl_t;

endpackage

// ===== rtl/cst_if.sv =====
// Interfaces: sample and result channels with valid/ready handshake.
interface cst_sample_if;
  logic        valid;
  logic        ready;
  logic [8:0]  hue_degrees;
  logic [7:0]  proximity_level;
  logic [13:0] range_mm;

  modport source(output valid, output hue_degrees, output proximity_level,
                 output range_mm, input ready);
  modport sink(input valid, input hue_degrees, input proximity_level,
               input range_mm, output ready);
endinterface

interface cst_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] current_colour;
  logic       pushed;
  logic       overflow;
  logic       popped;
  logic [1:0] popped_colour;
  logic       eject;
  logic [3:0] queue_count;

  modport source(output valid, output current_colour, output pushed, output overflow,
                 output popped, output popped_colour, output eject,
                 output queue_count, input ready);
  modport sink(input valid, input current_colour, input pushed, input overflow,
               input popped, input popped_colour, input eject,
               input queue_count, output ready);
endinterface

// ===== rtl/colour_sort_tracker.sv =====
// Top level: colour sort tracker with register port and queue cell chain.
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  ----------------------------------------------
//  sample    in   valid/ready         hue_degrees, proximity_level, range_mm
//  result    out  valid/ready         current_colour, pushed, overflow, popped,
//                                     popped_colour, eject, queue_count
//  APB       in   psel/penable/pwrite 6 regs at 4*index, pready tied high
//
// One item per cycle unless the result stalls. A sample is classified and the
// queue updated in the cycle it is accepted; its result shows in the next cycle
// from the output register. sample.ready stays high while that register is empty
// or being drained, so a full result only stalls the input when result.ready is low.
// Synchronous reset empties the queue (cell valid bits), clears the last
// colour/range and loads register defaults; no clearing pass is needed.
// The queue is a row of QUEUE_DEPTH cells, front at cell 0; a pop moves
// every cell down by one in the same cycle.
module colour_sort_tracker #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  cst_sample_if.sink                  sample,
  cst_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cst_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // ---------------------------------------------------------------- registers
  logic        sort_enable;
  logic        team_is_red;
  logic [7:0]  proximity_threshold;
  logic [13:0] distance_threshold;
  logic [8:0]  red_hue_limit;
  logic [8:0]  blue_hue_limit;

  logic [2:0]  reg_idx;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_enable         <= cst_pkg::RST_SORT_ENABLE;
      team_is_red         <= cst_pkg::RST_TEAM_IS_RED;
      proximity_threshold <= cst_pkg::RST_PROX_THRESH;
      distance_threshold  <= cst_pkg::RST_DIST_THRESH;
      red_hue_limit       <= cst_pkg::RST_RED_HUE;
      blue_hue_limit      <= cst_pkg::RST_BLUE_HUE;
    end else if (cfg_write) begin
      case (reg_idx)
        cst_pkg::REG_SORT_ENABLE:   sort_enable         <= pwdata[0];
        cst_pkg::REG_TEAM_IS_RED:   team_is_red         <= pwdata[0];
        cst_pkg::REG_PROX_THRESH:   proximity_threshold <= pwdata[7:0];
        cst_pkg::REG_DIST_THRESH:   distance_threshold  <= pwdata[13:0];
        cst_pkg::REG_RED_HUE_LIMIT: red_hue_limit       <= pwdata[8:0];
        cst_pkg::REG_BLUE_HUE_LIM:  blue_hue_limit      <= pwdata[8:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cst_pkg::REG_SORT_ENABLE:   prdata = {31'd0, sort_enable};
      cst_pkg::REG_TEAM_IS_RED:   prdata = {31'd0, team_is_red};
      cst_pkg::REG_PROX_THRESH:   prdata = {24'd0, proximity_threshold};
      cst_pkg::REG_DIST_THRESH:   prdata = {18'd0, distance_threshold};
      cst_pkg::REG_RED_HUE_LIMIT: prdata = {23'd0, red_hue_limit};
      cst_pkg::REG_BLUE_HUE_LIM:  prdata = {23'd0, blue_hue_limit};
      default:                    prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------- handshakes
  logic res_valid;
  logic take;

  assign sample.ready = !res_valid || result.ready;
  assign take         = sample.valid && sample.ready;

  // ---------------------------------------------------------- classification
  cst_pkg::colour_t cur_colour;
  cst_pkg::colour_t last_colour;
  logic [13:0]      last_range;

  always_comb begin
    cur_colour = cst_pkg::COL_NONE;
    if (sample.proximity_level > proximity_threshold) begin
      if (sample.hue_degrees < red_hue_limit) begin
        cur_colour = cst_pkg::COL_RED;
      end else if (sample.hue_degrees > blue_hue_limit) begin
        cur_colour = cst_pkg::COL_BLUE;
      end
    end
  end

  // ------------------------------------------------------------ queue control
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_colour;
  logic [QUEUE_DEPTH:0]   upper_valid_vec;
  logic [QUEUE_DEPTH:0]   upper_colour_vec;
  logic [QUEUE_DEPTH:0]   lower_valid_vec;
  logic [CW-1:0]          fifo_count;
  logic [CW-1:0]          fifo_count_next;

  logic             step;        // accepted item while sorting is enabled
  logic             new_colour;  // class changed to red or blue
  logic             full;
  logic             do_push;
  logic             do_ovf;
  logic             at_eject;    // range just fell below the threshold
  logic             do_pop;
  logic             front_blue;
  logic             do_eject;
  cst_pkg::colour_t pop_colour;
  cst_pkg::cell_ctrl_t ctrl;

  assign step       = take && sort_enable;
  assign new_colour = (cur_colour != cst_pkg::COL_NONE) && (cur_colour != last_colour);
  assign full       = cell_valid[QUEUE_DEPTH-1];
  assign do_push    = step && new_colour && !full;
  assign do_ovf     = step && new_colour && full;
  assign at_eject   = (sample.range_mm < distance_threshold) &&
                      (last_range >= distance_threshold);
  // the push comes first, so a freshly pushed item can pop from an empty queue
  assign do_pop     = step && at_eject && (cell_valid[0] || do_push);

  assign front_blue = cell_valid[0] ? cell_colour[0] : (cur_colour == cst_pkg::COL_BLUE);
  assign pop_colour = !do_pop ? cst_pkg::COL_NONE :
                      (front_blue ? cst_pkg::COL_BLUE : cst_pkg::COL_RED);
  assign do_eject   = do_pop && (team_is_red ? front_blue : !front_blue);

  assign ctrl.push = do_push;
  assign ctrl.pop  = do_pop;
  assign ctrl.blue = (cur_colour == cst_pkg::COL_BLUE);

  // neighbor links: tail sees an empty cell above, front sees a full one below
  assign upper_valid_vec  = {1'b0, cell_valid};
  assign upper_colour_vec = {1'b0, cell_colour};
  assign lower_valid_vec  = {cell_valid, 1'b1};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cst_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .lower_valid  (lower_valid_vec[i]),
      .upper_valid  (upper_valid_vec[i+1]),
      .upper_colour (upper_colour_vec[i+1]),
      .valid        (cell_valid[i]),
      .colour       (cell_colour[i])
    );
  end

  always_comb begin
    fifo_count_next = fifo_count;
    if (do_push && !do_pop) begin
      fifo_count_next = fifo_count + CNT_ONE;
    end else if (do_pop && !do_push) begin
      fifo_count_next = fifo_count - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count  <= '0;
      last_colour <= cst_pkg::COL_NONE;
      last_range  <= 14'd0;
    end else if (step) begin
      fifo_count  <= fifo_count_next;
      last_colour <= cur_colour;
      last_range  <= sample.range_mm;
    end
  end

  // ------------------------------------------------------------ result stage
  logic [CW+3:0] count_ext;

  assign count_ext = {4'd0, fifo_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.current_colour <= step ? cur_colour : cst_pkg::COL_NONE;
      result.pushed         <= do_push;
      result.overflow       <= do_ovf;
      result.popped         <= do_pop;
      result.popped_colour  <= pop_colour;
      result.eject          <= do_eject;
      result.queue_count    <= count_ext[3:0];
    end
  end

  assign result.valid = res_valid;

endmodule

// ===== rtl/cst_cell.sv =====
// Queue cell: one FIFO slot; shifts toward the front on a pop.
module cst_cell (
  input  logic                clk,
  input  logic                rst,
  input  cst_pkg::cell_ctrl_t ctrl,
  input  logic                lower_valid,   // neighbor nearer the front (1 at front)
  input  logic                upper_valid,   // neighbor nearer the tail (0 at tail)
  input  logic                upper_colour,
  output logic                valid,
  output logic                colour
);

  logic push_here;
  logic push_upper;
  logic valid_next;
  logic colour_next;

  // The push lands in the first empty cell.
  assign push_here  = ctrl.push && !valid && lower_valid;
  assign push_upper = ctrl.push && !upper_valid && valid;

  always_comb begin
    if (ctrl.pop) begin
      // take what the upper neighbor holds after this cycle's push
      valid_next  = upper_valid || push_upper;
      colour_next = push_upper ? ctrl.blue : upper_colour;
    end else begin
      valid_next  = valid || push_here;
      colour_next = push_here ? ctrl.blue : colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    colour <= colour_next;
  end

endmodule

// ===== rtl/cst_checker.sv =====
// Checker: port-level properties of the colour sort tracker, with bind.
module cst_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] current_colour,
  input logic       pushed,
  input logic       overflow,
  input logic       popped,
  input logic [1:0] popped_colour,
  input logic       eject
);

  // a stalled result keeps its valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_eject_needs_pop: assert property (@(posedge clk) disable iff (rst)
    res_valid && eject |-> popped)
    else $error("eject without a pop");

  a_push_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && pushed |-> !overflow && current_colour != cst_pkg::COL_NONE)
    else $error("push with overflow or without a colour");

  a_pop_colour: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (popped && (popped_colour == cst_pkg::COL_RED ||
                              popped_colour == cst_pkg::COL_BLUE)) ||
                  (!popped && popped_colour == cst_pkg::COL_NONE))
    else $error("popped colour does not match popped flag");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind colour_sort_tracker cst_checker u_cst_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .current_colour (result.current_colour),
  .pushed         (result.pushed),
  .overflow       (result.overflow),
  .popped         (result.popped),
  .popped_colour  (result.popped_colour),
  .eject          (result.eject)
);

// ===== tb/tb_colour_sort_tracker.sv =====
// Testbench: colour sort tracker, checked item by item against a behavioral predictor.
`timescale 1ns / 100ps

module tb_colour_sort_tracker;

  localparam int QUEUE_SLOTS = 8;
  // Register slots past the last real register; writes there must be dropped.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // One sensor sample as it travels on the sample channel.
  typedef struct packed {
    logic [8:0]  hue_degrees;
    logic [7:0]  proximity_level;
    logic [13:0] range_mm;
  } sample_t;

  // One step's outcome as it travels on the result channel.
  typedef struct packed {
    cst_pkg::colour_t current_colour;
    logic             pushed;
    logic             overflow;
    logic             popped;
    cst_pkg::colour_t popped_colour;
    logic             eject;
    logic [3:0]       queue_count;
  } tally_t;

  // Shadow of the register file.
  typedef struct packed {
    logic        enable;
    logic        team_red;
    logic [7:0]  prox_limit;
    logic [13:0] reach_limit;
    logic [8:0]  red_limit;
    logic [8:0]  blue_limit;
  } sorter_cfg_t;

  // Receiver back-pressure styles, switched each time stall_clock wraps to zero.
  typedef enum logic [1:0] {
    ALWAYS_READY,
    COIN_FLIP,
    MOSTLY_STALLED,
    PERIODIC
  } stall_style_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [cst_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  cst_sample_if smp();
  cst_result_if res();

  colour_sort_tracker #(.QUEUE_DEPTH(QUEUE_SLOTS)) uut (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register shadow, last class, last range and the bin
  // queue of colours waiting for the eject point (front = oldest).
  // ---------------------------------------------------------------------------
  sorter_cfg_t sorter_cfg = '{enable: cst_pkg::RST_SORT_ENABLE,
                              team_red: cst_pkg::RST_TEAM_IS_RED,
                              prox_limit: cst_pkg::RST_PROX_THRESH,
                              reach_limit: cst_pkg::RST_DIST_THRESH,
                              red_limit: cst_pkg::RST_RED_HUE,
                              blue_limit: cst_pkg::RST_BLUE_HUE};
  cst_pkg::colour_t seen_colour = cst_pkg::COL_NONE;
  logic [13:0]      seen_range  = '0;
  cst_pkg::colour_t bin_queue[$];

  sample_t     sample_backlog[$];   // items still to be offered by the driver
  tally_t      expected_tallies[$]; // predicted outcomes, oldest first
  int          mismatches = 0;
  bit          sample_taken = 1'b0; // set at the edge that accepted backlog[0]
  bit          slot_free;
  int          gap_left = 0;
  int          burst_left = 1;
  stall_style_t stall_style = ALWAYS_READY;
  logic [5:0]  stall_clock = '0;
  tally_t      got_tally;
  tally_t      want_tally;
  sample_t     taken_sample;

  // Classify one sample, then update the bin queue: a push for a change to a
  // new colour comes first, so an empty queue can push and pop in one step.
  function automatic tally_t track_sample(input sample_t s);
    tally_t           r;
    cst_pkg::colour_t cls;
    r = '0;
    r.current_colour = cst_pkg::COL_NONE;
    r.popped_colour  = cst_pkg::COL_NONE;
    if (sorter_cfg.enable) begin
      cls = cst_pkg::COL_NONE;
      if (s.proximity_level > sorter_cfg.prox_limit) begin
        // red wins where the hue limits overlap
        if (s.hue_degrees < sorter_cfg.red_limit) cls = cst_pkg::COL_RED;
        else if (s.hue_degrees > sorter_cfg.blue_limit) cls = cst_pkg::COL_BLUE;
      end
      r.current_colour = cls;
      if (cls != cst_pkg::COL_NONE && cls != seen_colour) begin
        if (bin_queue.size() >= QUEUE_SLOTS) begin
          r.overflow = 1'b1;   // dropped, but the class is still remembered
        end else begin
          bin_queue.insert(bin_queue.size(), cls);
          r.pushed = 1'b1;
        end
      end
      seen_colour = cls;
      // pop only on the falling crossing of the distance threshold
      if (s.range_mm < sorter_cfg.reach_limit && seen_range >= sorter_cfg.reach_limit &&
          bin_queue.size() > 0) begin
        r.popped_colour = bin_queue[0];
        bin_queue.delete(0);
        r.popped = 1'b1;
        r.eject = sorter_cfg.team_red ? (r.popped_colour == cst_pkg::COL_BLUE)
                                      : (r.popped_colour == cst_pkg::COL_RED);
      end
      seen_range = s.range_mm;
    end
    // disabled: everything frozen, result carries only the held count
    r.queue_count = 4'(bin_queue.size());
    return r;
  endfunction

  // Random sample shaped by the current settings. steer_pct: chance of a
  // clean red or blue sample; close_pct: chance of a range below threshold.
  function automatic sample_t make_sample(input int steer_pct, input int close_pct);
    sample_t s;
    s.hue_degrees     = 9'($urandom_range(0, 511));
    s.proximity_level = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < steer_pct) begin
      if ($urandom_range(0, 1) == 0 && sorter_cfg.red_limit > 0)
        s.hue_degrees = 9'($urandom_range(0, int'(sorter_cfg.red_limit) - 1));
      else if (sorter_cfg.blue_limit < 9'd511)
        s.hue_degrees = 9'($urandom_range(int'(sorter_cfg.blue_limit) + 1, 511));
      if (sorter_cfg.prox_limit < 8'd255)
        s.proximity_level = 8'($urandom_range(int'(sorter_cfg.prox_limit) + 1, 255));
    end
    if ($urandom_range(0, 99) < close_pct && sorter_cfg.reach_limit > 0)
      s.range_mm = 14'($urandom_range(0, int'(sorter_cfg.reach_limit) - 1));
    else
      s.range_mm = 14'($urandom_range(int'(sorter_cfg.reach_limit), 16383));
    return s;
  endfunction

  task automatic queue_sample(input int hue, input int prox, input int reach);
    sample_t s;
    s = '{hue_degrees: 9'(hue), proximity_level: 8'(prox), range_mm: 14'(reach)};
    sample_backlog.insert(sample_backlog.size(), s);
  endtask

  task automatic feed_random(input int count, input int steer_pct, input int close_pct);
    for (int i = 0; i < count; i++)
      sample_backlog.insert(sample_backlog.size(), make_sample(steer_pct, close_pct));
  endtask

  // Hold off until the driver is empty and every predicted result is back.
  task automatic settle();
    while (sample_backlog.size() != 0 || expected_tallies.size() != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the shadow follows the bus.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] word);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cst_pkg::REG_SORT_ENABLE:   sorter_cfg.enable      = word[0];
      cst_pkg::REG_TEAM_IS_RED:   sorter_cfg.team_red    = word[0];
      cst_pkg::REG_PROX_THRESH:   sorter_cfg.prox_limit  = word[7:0];
      cst_pkg::REG_DIST_THRESH:   sorter_cfg.reach_limit = word[13:0];
      cst_pkg::REG_RED_HUE_LIMIT: sorter_cfg.red_limit   = word[8:0];
      cst_pkg::REG_BLUE_HUE_LIM:  sorter_cfg.blue_limit  = word[8:0];
      default: ;
    endcase
  endtask

  // Junk above the field width checks that the block masks it off.
  task automatic write_field(input logic [2:0] idx, input logic [31:0] value,
                             input int width);
    logic [31:0] keep;
    logic [31:0] word;
    keep = (32'd1 << width) - 32'd1;
    word = ($urandom & ~keep) | (value & keep);
    apb_write(idx, word);
  endtask

  task automatic apply_setup(input logic en, input logic team, input int prox,
                             input int reach, input int red, input int blue);
    write_field(cst_pkg::REG_SORT_ENABLE, 32'(en), 1);
    write_field(cst_pkg::REG_TEAM_IS_RED, 32'(team), 1);
    write_field(cst_pkg::REG_PROX_THRESH, 32'(prox), 8);
    write_field(cst_pkg::REG_DIST_THRESH, 32'(reach), 14);
    write_field(cst_pkg::REG_RED_HUE_LIMIT, 32'(red), 9);
    write_field(cst_pkg::REG_BLUE_HUE_LIM, 32'(blue), 9);
  endtask

  task automatic compare_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Driver: offers backlog items in bursts of random length with random gaps.
  // valid never drops while an item waits to be taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      slot_free = !smp.valid || sample_taken;
      if (sample_taken) begin
        sample_backlog.delete(0);
        sample_taken = 1'b0;
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          smp.valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          smp.valid           <= 1'b1;
          smp.hue_degrees     <= sample_backlog[0].hue_degrees;
          smp.proximity_level <= sample_backlog[0].proximity_level;
          smp.range_mm        <= sample_backlog[0].range_mm;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // one burst in four runs straight into the next one
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: style changes whenever the 6-bit stall_clock wraps to zero.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_clock == '0) stall_style = stall_style_t'($urandom_range(0, 3));
    stall_clock++;
    case (stall_style)
      ALWAYS_READY:   res.ready <= 1'b1;
      COIN_FLIP:      res.ready <= 1'($urandom_range(0, 1));
      MOSTLY_STALLED: res.ready <= ($urandom_range(0, 3) == 0);
      default:        res.ready <= stall_clock[2];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted sample, check every accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (smp.valid && smp.ready) begin
        taken_sample = '{hue_degrees: smp.hue_degrees, proximity_level: smp.proximity_level,
                         range_mm: smp.range_mm};
        expected_tallies.insert(expected_tallies.size(), track_sample(taken_sample));
        sample_taken = 1'b1;
      end
      if (res.valid && res.ready) begin
        got_tally = '{current_colour: cst_pkg::colour_t'(res.current_colour),
                      pushed: res.pushed, overflow: res.overflow, popped: res.popped,
                      popped_colour: cst_pkg::colour_t'(res.popped_colour),
                      eject: res.eject, queue_count: res.queue_count};
        if (expected_tallies.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got_tally);
        end else begin
          want_tally = expected_tallies[0];
          expected_tallies.delete(0);
          compare_field("current_colour", 4'(want_tally.current_colour),
                        4'(got_tally.current_colour));
          compare_field("pushed", 4'(want_tally.pushed), 4'(got_tally.pushed));
          compare_field("overflow", 4'(want_tally.overflow), 4'(got_tally.overflow));
          compare_field("popped", 4'(want_tally.popped), 4'(got_tally.popped));
          compare_field("popped_colour", 4'(want_tally.popped_colour),
                        4'(got_tally.popped_colour));
          compare_field("eject", 4'(want_tally.eject), 4'(got_tally.eject));
          compare_field("queue_count", want_tally.queue_count, got_tally.queue_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and phase control
  // ---------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    smp.valid           = 1'b0;
    smp.hue_degrees     = '0;
    smp.proximity_level = '0;
    smp.range_mm        = '0;
    res.ready           = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings (prox > 100, range < 50, red < 30, blue > 100).
    queue_sample(50, 0, 16383);    // none; arms the range crossing
    queue_sample(0, 255, 0);       // red into an empty queue, popped in the same step
    queue_sample(511, 255, 16383); // hue beyond 359 still counts as blue
    queue_sample(29, 101, 50);     // red just inside both limits
    queue_sample(101, 101, 50);    // blue just inside
    queue_sample(30, 255, 50);     // red limit itself: none
    queue_sample(100, 255, 50);    // blue limit itself: none
    queue_sample(0, 100, 50);      // proximity at threshold: none
    queue_sample(0, 101, 50);
    queue_sample(359, 200, 60);
    queue_sample(10, 200, 60);
    queue_sample(200, 200, 60);
    queue_sample(5, 200, 60);      // queue now full
    queue_sample(400, 200, 60);    // push into full queue: overflow
    queue_sample(400, 200, 49);    // same colour, no push; crossing pops a blue
    queue_sample(5, 0, 0);         // below threshold but no fresh crossing
    queue_sample(0, 255, 16383);
    queue_sample(300, 255, 0);     // overflow and pop together
    settle();

    // Reset settings, random: first filling, then draining after a full pause.
    feed_random(120, 80, 50);
    settle();
    feed_random(80, 30, 50);
    settle();

    // Extremes: team blue, overlapping hue limits, widest thresholds.
    apply_setup(1'b1, 1'b0, 0, 16383, 359, 0);
    feed_random(100, 80, 50);
    settle();

    // Sorting off: samples ignored, state frozen. Spare addresses ignored too.
    apply_setup(1'b0, 1'b1, 255, 0, 0, 511);
    apb_write(REG_SPARE_LO, $urandom);
    apb_write(REG_SPARE_HI, $urandom);
    feed_random(50, 50, 50);
    settle();

    // Sorting on at the opposite extremes: nothing classifies, nothing pops.
    write_field(cst_pkg::REG_SORT_ENABLE, 32'd1, 1);
    feed_random(40, 80, 50);
    settle();

    // Mid-range settings with shared hue limit.
    apply_setup(1'b1, 1'b0, 128, 8191, 180, 180);
    feed_random(120, 75, 50);
    settle();

    // Random settings.
    for (int p = 0; p < 4; p++) begin
      apply_setup(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 230),
                  $urandom_range(0, 16383), $urandom_range(0, 511), $urandom_range(0, 511));
      feed_random(60, 75, 50);
      settle();
    end

    // Drain tail: idle cycles after the last result, before the verdict.
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
